// ===== design/lin_diag_request_segmenter_macros.svh =====
// Assertion macros for the LIN diagnostic request segmenter RTL, used by lds_out_stage.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LIN_DIAG_REQUEST_SEGMENTER_MACROS_SVH
`define LIN_DIAG_REQUEST_SEGMENTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define LDS_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("lin segmenter assertion failed");

// Next-cycle implication, checked outside reset.
`define LDS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("lin segmenter assertion failed");

`else

`define LDS_ASSERT_NOW(lbl, ant, cons)
`define LDS_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

// ===== design/lds_pkg.sv =====
// Shared types and constants for the LIN diagnostic request segmenter.
// Used by lds_out_stage and lin_diag_request_segmenter; no dependencies.
package lds_pkg;

    // Message length limits.
    localparam int unsigned MAX_MSG_LEN = 62;
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned SHORT_MAX   = 3;
    localparam int unsigned CONSEC_DATA = 6;

    // Frame byte constants.
    localparam logic [7:0] DEFAULT_TEMP_NAD = 8'hA0;
    localparam logic [7:0] PCI_ADDR_CMD     = 8'h06;
    localparam logic [7:0] SID_ASSIGN_NAD   = 8'hB0;
    localparam logic [7:0] SUPPLIER_WILD_LO = 8'h7F;
    localparam logic [7:0] PAD_BYTE         = 8'hFF;
    localparam logic [7:0] SID_WRITE_BY_ID  = 8'h2E;
    localparam logic [7:0] PCI_FIRST        = 8'h10;
    localparam logic [3:0] PCI_CONSEC_HI    = 4'h2;
    localparam logic [7:0] LEN_EXTRA        = 8'd3;

    typedef enum logic [2:0] {
        KIND_ASSIGN  = 3'd0,
        KIND_SINGLE  = 3'd1,
        KIND_FIRST   = 3'd2,
        KIND_CONSEC  = 3'd3,
        KIND_RESTORE = 3'd4
    } t_frame_kind;

    typedef logic [7:0][7:0] t_frame;

    // Frames produced by one accepted item, handed to the output stage.
    typedef struct packed {
        logic        has_assign;
        logic        has_data;
        logic        has_restore;
        t_frame_kind data_kind;
        logic [7:0]  node;
        logic [7:0]  temp;
        t_frame      data;
    } t_job;

endpackage

// ===== design/lin_diag_request_segmenter.sv =====
// Top level of the LIN diagnostic request segmenter: message state, frame build.
// Depends on lds_pkg and lds_out_stage.
// An accepted item is held in the output stage's job register and pending mask; its frames
// then move into one result register, one frame per cycle while the receiver is ready. An item is
// taken once the last frame of the item before moves into it. Reset (synchronous, active
// low) empties the output stage and message state, temp address 0xA0.
module lin_diag_request_segmenter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_node_address,
    input  logic [15:0] i_service_id,
    input  logic [5:0] i_message_length,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_frame_kind,
    output logic [7:0] o_byte_0,
    output logic [7:0] o_byte_1,
    output logic [7:0] o_byte_2,
    output logic [7:0] o_byte_3,
    output logic [7:0] o_byte_4,
    output logic [7:0] o_byte_5,
    output logic [7:0] o_byte_6,
    output logic [7:0] o_byte_7,
    output logic       o_last_in_run
);

    localparam int unsigned LW = lds_pkg::LEN_W;

    logic [7:0]    r_temp;
    logic [LW-1:0] r_taken;
    logic [7:0]    r_node;
    logic [15:0]   r_sid;
    logic [LW-1:0] r_len;
    logic [7:0]    r_data [lds_pkg::CONSEC_DATA];
    logic [3:0]    r_seq;
    logic [2:0]    r_pos;

    logic [LW-1:0] n_taken;
    logic [3:0]    n_seq;
    logic [2:0]    n_pos;

    logic          in_accept;
    logic          start;
    logic [LW:0]   len_clamp;
    logic [LW-1:0] len_eff;
    logic [7:0]    node_eff;
    logic [15:0]   sid_eff;
    logic [3:0]    seq_eff;
    logic [7:0]    len_pci;
    logic          last;
    logic          short_msg;
    logic          wr_en;
    logic [2:0]    wr_idx;
    logic [7:0]    merged [lds_pkg::CONSEC_DATA];
    logic          consec_path;
    logic          job_valid;
    lds_pkg::t_job job;
    lds_pkg::t_frame_kind out_kind;
    lds_pkg::t_frame      out_frame;

    assign in_accept = i_in_valid && o_in_ready;

    // Message fields: latched on the first item, held values afterwards.
    always_comb begin
        start     = (r_taken == '0);
        len_clamp = {1'b0, i_message_length};
        if (len_clamp == '0) begin
            len_clamp = (LW+1)'(1);
        end else if (len_clamp > (LW+1)'(lds_pkg::MAX_MSG_LEN)) begin
            len_clamp = (LW+1)'(lds_pkg::MAX_MSG_LEN);
        end
        len_eff   = start ? len_clamp[LW-1:0] : r_len;
        node_eff  = start ? i_node_address : r_node;
        sid_eff   = start ? i_service_id : r_sid;
        seq_eff   = start ? 4'd1 : r_seq;
        len_pci   = 8'(len_eff) + lds_pkg::LEN_EXTRA;
        last      = ({1'b0, r_taken} + (LW+1)'(1)) >= {1'b0, len_eff};
        short_msg = ({1'b0, len_eff} <= (LW+1)'(lds_pkg::SHORT_MAX));
        consec_path = !short_msg && (r_taken > LW'(1));
    end

    // Where the current data byte goes in the six-entry buffer.
    always_comb begin
        wr_en  = 1'b1;
        wr_idx = 3'd0;
        if (short_msg) begin
            wr_idx = r_taken[2:0];
        end else if (r_taken == LW'(1)) begin
            wr_en = 1'b0;
        end else if (consec_path) begin
            wr_idx = r_pos;
        end
        for (int i = 0; i < lds_pkg::CONSEC_DATA; i++) begin
            merged[i] = (wr_en && (wr_idx == 3'(i))) ? i_data_byte : r_data[i];
        end
    end

    // Data frame and the set of frames this item causes.
    always_comb begin
        job.has_assign  = start;
        job.has_restore = last;
        job.has_data    = 1'b0;
        job.data_kind   = lds_pkg::KIND_SINGLE;
        job.node        = node_eff;
        job.temp        = r_temp;
        job.data        = {8{lds_pkg::PAD_BYTE}};
        job.data[0]     = r_temp;
        if (short_msg) begin
            job.has_data = last;
            job.data[1]  = len_pci;
            job.data[2]  = lds_pkg::SID_WRITE_BY_ID;
            job.data[3]  = sid_eff[15:8];
            job.data[4]  = sid_eff[7:0];
            for (int i = 0; i < 3; i++) begin
                if (len_eff > LW'(i)) begin
                    job.data[5+i] = merged[i];
                end
            end
        end else if (r_taken == LW'(1)) begin
            job.has_data  = 1'b1;
            job.data_kind = lds_pkg::KIND_FIRST;
            job.data[1]   = lds_pkg::PCI_FIRST;
            job.data[2]   = len_pci;
            job.data[3]   = lds_pkg::SID_WRITE_BY_ID;
            job.data[4]   = sid_eff[15:8];
            job.data[5]   = sid_eff[7:0];
            job.data[6]   = r_data[0];
            job.data[7]   = i_data_byte;
        end else if (consec_path) begin
            job.has_data  = (r_pos == 3'(lds_pkg::CONSEC_DATA - 1)) || last;
            job.data_kind = lds_pkg::KIND_CONSEC;
            job.data[1]   = {lds_pkg::PCI_CONSEC_HI, seq_eff};
            for (int i = 0; i < lds_pkg::CONSEC_DATA; i++) begin
                if (3'(i) <= r_pos) begin
                    job.data[2+i] = merged[i];
                end
            end
        end
        job_valid = i_in_valid && (job.has_assign || job.has_data || job.has_restore);
    end

    // Next values of the message counters.
    always_comb begin
        n_taken = last ? '0 : r_taken + LW'(1);
        if (last) begin
            n_seq = 4'd1;
        end else if (consec_path && job.has_data) begin
            n_seq = seq_eff + 4'd1;
        end else begin
            n_seq = seq_eff;
        end
        if (consec_path) begin
            n_pos = (r_pos == 3'(lds_pkg::CONSEC_DATA - 1)) ? 3'd0 : r_pos + 3'd1;
        end else begin
            n_pos = 3'd0;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= lds_pkg::DEFAULT_TEMP_NAD;
        end else if (i_cfg_wr_en) begin
            r_temp <= i_cfg_wr_data;
        end
    end

    // Message state, updated on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_node  <= '0;
            r_sid   <= '0;
            r_len   <= '0;
            r_seq   <= 4'd1;
            r_pos   <= 3'd0;
        end else if (in_accept) begin
            r_taken <= n_taken;
            r_node  <= node_eff;
            r_sid   <= sid_eff;
            r_len   <= len_eff;
            r_seq   <= n_seq;
            r_pos   <= n_pos;
        end
    end

    // Payload byte buffer; no reset, every entry is written before it is read.
    always_ff @(posedge i_clk) begin
        if (in_accept && wr_en) begin
            r_data[wr_idx] <= i_data_byte;
        end
    end

    lds_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_ready   (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_kind  (out_kind),
        .o_frame       (out_frame),
        .o_last_in_run (o_last_in_run)
    );

    assign o_frame_kind = out_kind;
    assign o_byte_0     = out_frame[0];
    assign o_byte_1     = out_frame[1];
    assign o_byte_2     = out_frame[2];
    assign o_byte_3     = out_frame[3];
    assign o_byte_4     = out_frame[4];
    assign o_byte_5     = out_frame[5];
    assign o_byte_6     = out_frame[6];
    assign o_byte_7     = out_frame[7];

endmodule

// ===== design/lds_out_stage.sv =====
// Output stage: holds the frames of one item and sends them one per cycle while the receiver is ready.
// Depends on lds_pkg and lin_diag_request_segmenter_macros.svh.
`include "lin_diag_request_segmenter_macros.svh"

module lds_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  lds_pkg::t_job       i_job,
    output logic                o_job_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lds_pkg::t_frame_kind o_frame_kind,
    output lds_pkg::t_frame     o_frame,
    output logic                o_last_in_run
);

    // Pending mask: bit 0 assign, bit 1 data, bit 2 restore.
    logic [2:0]           r_pend;
    logic [2:0]           n_pend;
    lds_pkg::t_job        r_job;
    logic                 r_out_valid;
    lds_pkg::t_frame_kind r_kind;
    lds_pkg::t_frame      r_frame;
    logic                 r_last;

    logic                 pop;
    logic                 load;
    logic [2:0]           remaining;
    lds_pkg::t_frame_kind sel_kind;
    lds_pkg::t_frame      sel_frame;
    lds_pkg::t_frame      addr_frame;

    // Pick the oldest pending frame, in the order assign, data, restore.
    always_comb begin
        pop       = (r_pend != 3'b000) && (!r_out_valid || i_out_ready);
        remaining = r_pend;
        sel_kind  = lds_pkg::KIND_RESTORE;
        if (r_pend[0]) begin
            remaining[0] = 1'b0;
            sel_kind     = lds_pkg::KIND_ASSIGN;
        end else if (r_pend[1]) begin
            remaining[1] = 1'b0;
            sel_kind     = r_job.data_kind;
        end else begin
            remaining[2] = 1'b0;
        end
        o_job_ready = (r_pend == 3'b000) || (pop && (remaining == 3'b000));
        load        = i_job_valid && o_job_ready;
        if (load) begin
            n_pend = {i_job.has_restore, i_job.has_data, i_job.has_assign};
        end else if (pop) begin
            n_pend = remaining;
        end else begin
            n_pend = r_pend;
        end
    end

    // Assign and restore frames share one layout; only the last byte differs.
    always_comb begin
        addr_frame[0] = r_job.node;
        addr_frame[1] = lds_pkg::PCI_ADDR_CMD;
        addr_frame[2] = lds_pkg::SID_ASSIGN_NAD;
        addr_frame[3] = lds_pkg::PAD_BYTE;
        addr_frame[4] = lds_pkg::SUPPLIER_WILD_LO;
        addr_frame[5] = lds_pkg::PAD_BYTE;
        addr_frame[6] = lds_pkg::PAD_BYTE;
        addr_frame[7] = r_pend[0] ? r_job.temp : r_job.node;
        sel_frame     = (!r_pend[0] && r_pend[1]) ? r_job.data : addr_frame;
    end

    // Pending mask and held job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else begin
            r_pend <= n_pend;
        end
        if (load) begin
            r_job <= i_job;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (pop) begin
            r_kind  <= sel_kind;
            r_frame <= sel_frame;
            r_last  <= (remaining == 3'b000);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_kind  = r_kind;
    assign o_frame       = r_frame;
    assign o_last_in_run = r_last;

    // A frame taken from the job always lands in the result register.
    `LDS_ASSERT_NEXT(a_pop_fills_out, pop, r_out_valid)
    // Without a new job the pending mask only loses bits.
    `LDS_ASSERT_NEXT(a_pend_shrinks, !load, (r_pend & ~$past(r_pend)) == 3'b000)
    // The restore frame always closes the run of its item.
    `LDS_ASSERT_NEXT(a_restore_last, pop && (r_pend == 3'b100),
                     r_last && (r_kind == lds_pkg::KIND_RESTORE))
    // Loading a job only happens when nothing older is left behind.
    `LDS_ASSERT_NOW(a_no_overwrite, load && (r_pend != 3'b000),
                    pop && (remaining == 3'b000))

endmodule

// ===== verif/lin_diag_request_segmenter_tb.sv =====
// Self-checking testbench for lin_diag_request_segmenter: directed table, then random messages.
// Depends on lds_pkg and the segmenter RTL; frames are predicted in the bench and checked in order.
module lin_diag_request_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Frame bytes in wire order: index 0 is byte_0.
    typedef logic [0:7][7:0] t_frame_bytes;

    typedef struct packed {
        lds_pkg::t_frame_kind kind;
        t_frame_bytes         bytes;
        logic                 last;
    } t_exp_frame;

    // One directed item; n_typed frames are taken from the typed list instead of the predictor.
    typedef struct packed {
        logic [7:0]  node;
        logic [15:0] sid;
        logic [5:0]  len;
        logic [7:0]  data;
        logic [1:0]  n_typed;
    } t_stim_row;

    localparam int          DIR_N       = 24;
    localparam int          PHASE_ITEMS = 125;
    localparam int unsigned CYCLE_LIMIT = 400000;

    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        // One-byte message right after reset, all fields zero.
        '{8'h00, 16'h0000, 6'd0,  8'h00, 2'd3},
        // Length zero counts as one; all fields at their maximum.
        '{8'hFF, 16'hFFFF, 6'd0,  8'hFF, 2'd3},
        // Two bytes; the fields of the second item must be ignored.
        '{8'h3C, 16'h1234, 6'd2,  8'h11, 2'd0},
        '{8'hC3, 16'hEDCB, 6'd42, 8'h22, 2'd0},
        // Three bytes, the longest single frame.
        '{8'h55, 16'hAA55, 6'd3,  8'h80, 2'd0},
        '{8'hAA, 16'h55AA, 6'd1,  8'h7F, 2'd0},
        '{8'h00, 16'h0000, 6'd0,  8'h01, 2'd0},
        // Eight bytes: the last consecutive frame is full and the restore follows it.
        '{8'h01, 16'h00FF, 6'd8,  8'h10, 2'd0},
        '{8'hFE, 16'hFF00, 6'd63, 8'h11, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h12, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h13, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h14, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h15, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h16, 2'd0},
        '{8'h01, 16'h00FF, 6'd8,  8'h17, 2'd0},
        // Nine bytes: one full consecutive frame, then a padded one with a single byte.
        '{8'h80, 16'hFF00, 6'd9,  8'hA0, 2'd0},
        '{8'h7F, 16'h00FF, 6'd63, 8'hA1, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA2, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA3, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA4, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA5, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA6, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA7, 2'd0},
        '{8'h80, 16'hFF00, 6'd9,  8'hA8, 2'd0}
    };

    // Frames of the first two directed messages, written out by hand.
    localparam t_exp_frame TYPED_FRAMES [6] = '{
        '{lds_pkg::KIND_ASSIGN,  64'h00_06_B0_FF_7F_FF_FF_A0, 1'b0},
        '{lds_pkg::KIND_SINGLE,  64'hA0_04_2E_00_00_00_FF_FF, 1'b0},
        '{lds_pkg::KIND_RESTORE, 64'h00_06_B0_FF_7F_FF_FF_00, 1'b1},
        '{lds_pkg::KIND_ASSIGN,  64'hFF_06_B0_FF_7F_FF_FF_A0, 1'b0},
        '{lds_pkg::KIND_SINGLE,  64'hA0_04_2E_FF_FF_FF_FF_FF, 1'b0},
        '{lds_pkg::KIND_RESTORE, 64'hFF_06_B0_FF_7F_FF_FF_FF, 1'b1}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_node_address;
    logic [15:0] i_service_id;
    logic [5:0]  i_message_length;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_frame_kind;
    logic [7:0]  o_byte_0, o_byte_1, o_byte_2, o_byte_3;
    logic [7:0]  o_byte_4, o_byte_5, o_byte_6, o_byte_7;
    logic        o_last_in_run;

    // Predicted message state of the segmenter.
    logic [7:0]  temp_nad = lds_pkg::DEFAULT_TEMP_NAD;
    int unsigned taken_cnt = 0;
    logic [7:0]  msg_node = '0;
    logic [15:0] msg_sid = '0;
    int unsigned msg_len = 0;
    logic [7:0]  held [6];
    logic [3:0]  seq_no = 4'd1;

    t_exp_frame  built [$];
    t_exp_frame  frames_due [$];
    int          typed_pos = 0;
    int          items_sent = 0;
    int          frames_seen = 0;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_left = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    lin_diag_request_segmenter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_node_address   (i_node_address),
        .i_service_id     (i_service_id),
        .i_message_length (i_message_length),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_kind     (o_frame_kind),
        .o_byte_0         (o_byte_0),
        .o_byte_1         (o_byte_1),
        .o_byte_2         (o_byte_2),
        .o_byte_3         (o_byte_3),
        .o_byte_4         (o_byte_4),
        .o_byte_5         (o_byte_5),
        .o_byte_6         (o_byte_6),
        .o_byte_7         (o_byte_7),
        .o_last_in_run    (o_last_in_run)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Mostly short messages; a few long ones and the zero and saturating length fields.
    function automatic logic [5:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)  return 6'd0;
        if (roll < 8)  return 6'd63;
        if (roll < 45) return 6'($urandom_range(1, 3));
        if (roll < 78) return 6'($urandom_range(4, 14));
        if (roll < 93) return 6'($urandom_range(15, 40));
        return 6'($urandom_range(41, 62));
    endfunction

    // Address frame: byte 0 is the node spoken to, byte 7 the address it is given.
    function automatic t_frame_bytes addr_frame(input logic [7:0] target, input logic [7:0] nad);
        return {target, lds_pkg::PCI_ADDR_CMD, lds_pkg::SID_ASSIGN_NAD, lds_pkg::PAD_BYTE,
                lds_pkg::SUPPLIER_WILD_LO, lds_pkg::PAD_BYTE, lds_pkg::PAD_BYTE, nad};
    endfunction

    // Advance the predicted message state by one payload item and collect its frames in built.
    function automatic void segment_byte(input logic [7:0] node, input logic [15:0] sid,
                                         input logic [5:0] len_f, input logic [7:0] d);
        int unsigned  k;
        int unsigned  pos;
        bit           last;
        t_frame_bytes fb;
        t_exp_frame   tail;
        built.delete();

        // The first item of a message latches its header and moves the node.
        if (taken_cnt == 0) begin
            if (len_f == 0)
                msg_len = 1;
            else if (len_f > lds_pkg::MAX_MSG_LEN)
                msg_len = lds_pkg::MAX_MSG_LEN;
            else
                msg_len = len_f;
            msg_node = node;
            msg_sid  = sid;
            seq_no   = 4'd1;
            built.push_back('{lds_pkg::KIND_ASSIGN, addr_frame(node, temp_nad), 1'b0});
        end

        k    = taken_cnt;
        last = (k + 1 >= msg_len);

        if (msg_len <= lds_pkg::SHORT_MAX) begin
            // Short message: one single frame once every byte is in.
            held[k] = d;
            if (last) begin
                fb    = {8{lds_pkg::PAD_BYTE}};
                fb[0] = temp_nad;
                fb[1] = lds_pkg::LEN_EXTRA + msg_len[7:0];
                fb[2] = lds_pkg::SID_WRITE_BY_ID;
                fb[3] = msg_sid[15:8];
                fb[4] = msg_sid[7:0];
                for (int i = 0; i < msg_len; i++)
                    fb[5 + i] = held[i];
                built.push_back('{lds_pkg::KIND_SINGLE, fb, 1'b0});
            end
        end else if (k == 0) begin
            held[0] = d;
        end else if (k == 1) begin
            // First frame carries the header and the first two bytes.
            fb = {temp_nad, lds_pkg::PCI_FIRST, lds_pkg::LEN_EXTRA + msg_len[7:0],
                  lds_pkg::SID_WRITE_BY_ID, msg_sid[15:8], msg_sid[7:0], held[0], d};
            built.push_back('{lds_pkg::KIND_FIRST, fb, 1'b0});
        end else begin
            // Consecutive frames of up to six bytes, padded on the last one.
            pos       = (k - 2) % lds_pkg::CONSEC_DATA;
            held[pos] = d;
            if (pos == lds_pkg::CONSEC_DATA - 1 || last) begin
                fb    = {8{lds_pkg::PAD_BYTE}};
                fb[0] = temp_nad;
                fb[1] = {lds_pkg::PCI_CONSEC_HI, seq_no};
                for (int i = 0; i <= pos; i++)
                    fb[2 + i] = held[i];
                built.push_back('{lds_pkg::KIND_CONSEC, fb, 1'b0});
                seq_no = seq_no + 4'd1;
            end
        end

        if (last) begin
            built.push_back('{lds_pkg::KIND_RESTORE, addr_frame(msg_node, msg_node), 1'b0});
            taken_cnt = 0;
            seq_no    = 4'd1;
        end else begin
            taken_cnt = (k + 1) % 64;
        end

        if (built.size() > 0) begin
            tail      = built[built.size() - 1];
            tail.last = 1'b1;
            built[built.size() - 1] = tail;
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        if (mismatches < 40)
            $display("[%0t] frame %0d: %s got %0h, wanted %0h",
                     $time, frames_seen, what, got_v, want_v);
        mismatches++;
    endtask

    // Present one item after an optional gap and wait for it to be taken. Entered at a falling edge.
    task automatic send_byte(input logic [7:0] node, input logic [15:0] sid,
                             input logic [5:0] len_f, input logic [7:0] d,
                             input logic [1:0] n_typed);
        int unsigned gap;
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_node_address   <= node;
        i_service_id     <= sid;
        i_message_length <= len_f;
        i_data_byte      <= d;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);

        segment_byte(node, sid, len_f, d);
        if (n_typed == 0) begin
            foreach (built[i])
                frames_due.push_back(built[i]);
        end else begin
            repeat (n_typed) begin
                frames_due.push_back(TYPED_FRAMES[typed_pos]);
                typed_pos++;
            end
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // One whole message; later items carry random header fields that must be ignored.
    task automatic send_message();
        logic [7:0]  node;
        logic [15:0] sid;
        case ($urandom_range(0, 9))
            0: node = 8'h00;
            1: node = 8'hFF;
            default: node = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: sid = 16'h0000;
            1: sid = 16'hFFFF;
            default: sid = 16'($urandom);
        endcase
        send_byte(node, sid, pick_length(), 8'($urandom), 2'd0);
        while (taken_cnt != 0)
            send_byte(8'($urandom), 16'($urandom), 6'($urandom), 8'($urandom), 2'd0);
    endtask

    // Drop valid, let every expected frame come out, then give the block time to go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_temp(input logic [7:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        temp_nad = v;
    endtask

    // Receiver stalls: random runs of low ready, none while out_calm is set.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  = stall_left - 1;
        end else if (!out_calm && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  = pick_gap();
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check every accepted frame against the oldest expected one.
    always @(posedge i_clk) begin
        t_exp_frame   want;
        t_frame_bytes got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_byte_0, o_byte_1, o_byte_2, o_byte_3,
                   o_byte_4, o_byte_5, o_byte_6, o_byte_7};
            if (frames_due.size() == 0) begin
                report_mismatch("frame with none expected, kind", o_frame_kind, 0);
            end else begin
                want = frames_due.pop_front();
                if (o_frame_kind !== want.kind)
                    report_mismatch("frame_kind", o_frame_kind, want.kind);
                for (int i = 0; i < 8; i++)
                    if (got[i] !== want.bytes[i])
                        report_mismatch($sformatf("byte_%0d", i), got[i], want.bytes[i]);
                if (o_last_in_run !== want.last)
                    report_mismatch("last_in_run", o_last_in_run, want.last);
            end
            frames_seen++;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_cnt, frames_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases each under its own temporary address.
    initial begin
        logic [7:0] temp_val;
        int         goal;
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        i_in_valid       = 1'b0;
        i_node_address   = '0;
        i_service_id     = '0;
        i_message_length = '0;
        i_data_byte      = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++)
            send_byte(DIR_ROWS[r].node, DIR_ROWS[r].sid, DIR_ROWS[r].len,
                      DIR_ROWS[r].data, DIR_ROWS[r].n_typed);

        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: temp_val = 8'h00;
                1: temp_val = 8'hFF;
                default: temp_val = 8'($urandom);
            endcase
            write_temp(temp_val);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                in_calm  = ($urandom_range(0, 5) == 0);
                out_calm = ($urandom_range(0, 5) == 0);
                send_message();
            end
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
